/* hw/rtl/btkhq_pkg.sv */
// ----------------------------------------------------------------------------
// btkhq_pkg
// Shared constants for the bounded top-k heap queue.
// ----------------------------------------------------------------------------
package btkhq_pkg;

    localparam int DEPTH_DEF    = 64;
    localparam int KEY_BITS_DEF = 32;
    localparam int TAG_BITS_DEF = 16;

    // configuration register file
    localparam int CAP_BITS     = 7;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = CAP_BITS;

    localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd64;

    localparam logic [CFG_IDX_BITS-1:0] REG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ORDER    = 2'd1;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

endpackage

/* hw/rtl/btkhq_ram.sv */
// ----------------------------------------------------------------------------
// btkhq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module btkhq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hw/rtl/bounded_top_k_heap_queue.sv */
// ----------------------------------------------------------------------------
// bounded_top_k_heap_queue
// Array binary heap keeping at most capacity keyed entries in one RAM.
// ----------------------------------------------------------------------------
// Sequencing: a push below capacity climbs, reading each parent then comparing;
//   a push into a full heap and a pop sift down from the root, reading the left
//   then the right child before comparing, all through the one RAM read port.
// Throughput: one request at a time; the next is taken once the current one's
//   result has moved into the output register, where it may still wait.
// Reset: count cleared, capacity 64, order 0; the RAM is not cleared.
// ----------------------------------------------------------------------------
module bounded_top_k_heap_queue #(
    parameter int DEPTH    = btkhq_pkg::DEPTH_DEF,
    parameter int KEY_BITS = btkhq_pkg::KEY_BITS_DEF,
    parameter int TAG_BITS = btkhq_pkg::TAG_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // request channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 mode,
    input  logic [KEY_BITS-1:0]                  key,
    input  logic [TAG_BITS-1:0]                  tag,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 accepted,
    output logic                                 error,
    output logic                                 top_valid,
    output logic [KEY_BITS-1:0]                  top_key,
    output logic [TAG_BITS-1:0]                  top_tag,
    output logic [$clog2(DEPTH+1)-1:0]           count,
    // configuration
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [btkhq_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [btkhq_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int IW   = AW + 2;
    localparam int W    = KEY_BITS + TAG_BITS;
    localparam int CMPW = (CW > btkhq_pkg::CAP_BITS) ? CW : btkhq_pkg::CAP_BITS;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_UP_RD  = 7'b0000010,
        S_UP_CMP = 7'b0000100,
        S_POP_RD = 7'b0001000,
        S_DN_RDL = 7'b0010000,
        S_DN_RDR = 7'b0100000,
        S_DN_CMP = 7'b1000000
    } state_t;

    // finish flag: result waiting to move into the output register
    state_t                         state_reg, state_next;
    logic                           fin_reg, fin_next;
    logic [CW-1:0]                  cnt_reg, cnt_next;
    logic [btkhq_pkg::CAP_BITS-1:0] cap_reg;
    logic                           order_reg;
    logic [KEY_BITS-1:0]            root_key_reg;
    logic [TAG_BITS-1:0]            root_tag_reg;
    logic [KEY_BITS-1:0]            cur_key_reg, cur_key_next;
    logic [TAG_BITS-1:0]            cur_tag_reg, cur_tag_next;
    logic [KEY_BITS-1:0]            lkey_reg, lkey_next;
    logic [TAG_BITS-1:0]            ltag_reg, ltag_next;
    logic [AW-1:0]                  idx_reg, idx_next;
    logic                           acc_reg, acc_next;
    logic                           err_reg, err_next;

    logic                           out_valid_reg;
    logic                           accepted_reg;
    logic                           error_reg;
    logic                           top_valid_reg;
    logic [KEY_BITS-1:0]            top_key_reg;
    logic [TAG_BITS-1:0]            top_tag_reg;
    logic [CW-1:0]                  count_reg;

    logic                           wr_en;
    logic [AW-1:0]                  wr_addr;
    logic [W-1:0]                   wr_data;
    logic                           rd_en;
    logic [AW-1:0]                  rd_addr;
    logic [W-1:0]                   rd_data;
    logic [KEY_BITS-1:0]            rd_key;
    logic [TAG_BITS-1:0]            rd_tag;

    logic                           in_fire;
    logic                           out_load;
    logic [CMPW-1:0]                eff_cap;
    logic                           below_cap;
    logic [AW-1:0]                  parent_idx;
    logic [IW-1:0]                  l_idx;
    logic [IW-1:0]                  r_idx;
    logic [IW-1:0]                  n_ext;
    logic                           l_in;
    logic                           r_in;
    logic                           pick_l;
    logic                           pick_r;
    logic [KEY_BITS-1:0]            pick_key;
    logic [CW-1:0]                  cnt_dec;

    function automatic logic loses(input logic [KEY_BITS-1:0] a,
                                   input logic [KEY_BITS-1:0] b,
                                   input logic                ord);
        return ord ? (a > b) : (a < b);
    endfunction

    btkhq_ram #(
        .WIDTH (W),
        .DEPTH (DEPTH)
    ) u_heap_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_key = rd_data[W-1:TAG_BITS];
    assign rd_tag = rd_data[TAG_BITS-1:0];

    assign in_ready  = (state_reg == S_IDLE) && !fin_reg;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_load  = fin_reg && (!out_valid_reg || out_ready);

    // capacity 0 acts as 1, anything above DEPTH as DEPTH
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CMPW'(1);
        end
        else if (CMPW'(cap_reg) > CMPW'(DEPTH))
        begin
            eff_cap = CMPW'(DEPTH);
        end
        else
        begin
            eff_cap = CMPW'(cap_reg);
        end
    end

    assign below_cap  = CMPW'(cnt_reg) < eff_cap;
    assign cnt_dec    = cnt_reg - 1'b1;
    assign parent_idx = AW'((idx_reg - 1'b1) >> 1);
    assign l_idx      = {1'b0, idx_reg, 1'b1};
    assign r_idx      = l_idx + 1'b1;
    assign n_ext      = IW'(cnt_reg);
    assign l_in       = l_idx < n_ext;
    assign r_in       = r_idx < n_ext;
    assign pick_l     = loses(cur_key_reg, lkey_reg, order_reg);
    assign pick_key   = pick_l ? lkey_reg : cur_key_reg;
    assign pick_r     = r_in && loses(pick_key, rd_key, order_reg);

    always_comb
    begin
        state_next   = state_reg;
        fin_next     = fin_reg;
        cnt_next     = cnt_reg;
        cur_key_next = cur_key_reg;
        cur_tag_next = cur_tag_reg;
        lkey_next    = lkey_reg;
        ltag_next    = ltag_reg;
        idx_next     = idx_reg;
        acc_next     = acc_reg;
        err_next     = err_reg;
        wr_en        = 1'b0;
        wr_addr      = idx_reg;
        wr_data      = {cur_key_reg, cur_tag_reg};
        rd_en        = 1'b0;
        rd_addr      = parent_idx;

        if (out_load)
        begin
            fin_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    acc_next     = 1'b0;
                    err_next     = 1'b0;
                    cur_key_next = key;
                    cur_tag_next = tag;
                    idx_next     = '0;
                    if (mode == btkhq_pkg::MODE_PUSH)
                    begin
                        if (below_cap)
                        begin
                            acc_next   = 1'b1;
                            cnt_next   = cnt_reg + 1'b1;
                            idx_next   = cnt_reg[AW-1:0];
                            state_next = S_UP_RD;
                        end
                        else if (!loses(root_key_reg, key, order_reg))
                        begin
                            acc_next   = 1'b1;
                            state_next = S_DN_RDL;
                        end
                        else
                        begin
                            fin_next = 1'b1;
                        end
                    end
                    else
                    begin
                        if (cnt_reg == '0)
                        begin
                            err_next = 1'b1;
                            fin_next = 1'b1;
                        end
                        else
                        begin
                            cnt_next = cnt_dec;
                            if (cnt_dec == '0)
                            begin
                                fin_next = 1'b1;
                            end
                            else
                            begin
                                // last entry moves to the root
                                rd_en      = 1'b1;
                                rd_addr    = cnt_dec[AW-1:0];
                                state_next = S_POP_RD;
                            end
                        end
                    end
                end
            end
            S_UP_RD:
            begin
                if (idx_reg == '0)
                begin
                    wr_en      = 1'b1;
                    fin_next   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                wr_en = 1'b1;
                if (loses(cur_key_reg, rd_key, order_reg))
                begin
                    fin_next   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    // parent moves down, equal keys rise
                    wr_data    = rd_data;
                    idx_next   = parent_idx;
                    state_next = S_UP_RD;
                end
            end
            S_POP_RD:
            begin
                cur_key_next = rd_key;
                cur_tag_next = rd_tag;
                state_next   = S_DN_RDL;
            end
            S_DN_RDL:
            begin
                if (l_in)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = l_idx[AW-1:0];
                    state_next = S_DN_RDR;
                end
                else
                begin
                    wr_en      = 1'b1;
                    fin_next   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DN_RDR:
            begin
                lkey_next = rd_key;
                ltag_next = rd_tag;
                if (r_in)
                begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx[AW-1:0];
                end
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                wr_en = 1'b1;
                if (pick_r)
                begin
                    wr_data    = rd_data;
                    idx_next   = r_idx[AW-1:0];
                    state_next = S_DN_RDL;
                end
                else if (pick_l)
                begin
                    wr_data    = {lkey_reg, ltag_reg};
                    idx_next   = l_idx[AW-1:0];
                    state_next = S_DN_RDL;
                end
                else
                begin
                    fin_next   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fin_reg       <= 1'b0;
            cnt_reg       <= '0;
            cap_reg       <= btkhq_pkg::CAP_RESET;
            order_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
            cnt_reg   <= cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    btkhq_pkg::REG_CAPACITY: cap_reg   <= cfg_data;
                    btkhq_pkg::REG_ORDER:    order_reg <= cfg_data[0];
                    default:                 ;
                endcase
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_key_reg <= cur_key_next;
        cur_tag_reg <= cur_tag_next;
        lkey_reg    <= lkey_next;
        ltag_reg    <= ltag_next;
        idx_reg     <= idx_next;
        acc_reg     <= acc_next;
        err_reg     <= err_next;
        // entry 0 mirrored in flops for the top outputs and full-heap compare
        if (wr_en && (wr_addr == '0))
        begin
            root_key_reg <= wr_data[W-1:TAG_BITS];
            root_tag_reg <= wr_data[TAG_BITS-1:0];
        end
        if (out_load)
        begin
            accepted_reg  <= acc_reg;
            error_reg     <= err_reg;
            top_valid_reg <= (cnt_reg != '0);
            top_key_reg   <= (cnt_reg != '0) ? root_key_reg : '0;
            top_tag_reg   <= (cnt_reg != '0) ? root_tag_reg : '0;
            count_reg     <= cnt_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign accepted  = accepted_reg;
    assign error     = error_reg;
    assign top_valid = top_valid_reg;
    assign top_key   = top_key_reg;
    assign top_tag   = top_tag_reg;
    assign count     = count_reg;

endmodule

/* hw/rtl/btkhq_checker.sv */
// ----------------------------------------------------------------------------
// btkhq_checker
// Port-level checks on the bounded top-k heap queue, bound to the top level.
// ----------------------------------------------------------------------------
module btkhq_checker #(
    parameter int DEPTH    = btkhq_pkg::DEPTH_DEF,
    parameter int KEY_BITS = btkhq_pkg::KEY_BITS_DEF,
    parameter int TAG_BITS = btkhq_pkg::TAG_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic                        accepted,
    input  logic                        error,
    input  logic                        top_valid,
    input  logic [KEY_BITS-1:0]         top_key,
    input  logic [TAG_BITS-1:0]         top_tag,
    input  logic [$clog2(DEPTH+1)-1:0]  count
);

    localparam int CW = $clog2(DEPTH + 1);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(count) && $stable(top_key)
            && $stable(top_tag) && $stable(accepted) && $stable(error))
        else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(accepted && error))
        else $error("accepted and error both set");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (top_valid == (count != '0)))
        else $error("top_valid disagrees with count");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !top_valid |-> (top_key == '0) && (top_tag == '0))
        else $error("empty heap shows nonzero top");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> count <= CW'(DEPTH))
        else $error("count above depth");

endmodule

bind bounded_top_k_heap_queue btkhq_checker #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS),
    .TAG_BITS (TAG_BITS)
) u_btkhq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .accepted  (accepted),
    .error     (error),
    .top_valid (top_valid),
    .top_key   (top_key),
    .top_tag   (top_tag),
    .count     (count)
);
